// ----- design/mcr_pkg.sv -----
`timescale 1ns / 1ps

package mcr_pkg;

	// Request codes carried in req_type.
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CAMERA_X = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CAMERA_Y = 1'b1;

	// Midpoint decision term constants: start value 3 - 2r, then +4i+6 or +4(i-j)+10.
	localparam int ERR_INIT    = 3;
	localparam int STEP_LINEAR = 6;
	localparam int STEP_DIAG   = 10;

	// Step queue between front and back; depth must be a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// Order of the four spans of one octant step.
	typedef enum logic [1:0] {
		SPAN_POS_I = 2'd0,
		SPAN_NEG_I = 2'd1,
		SPAN_POS_J = 2'd2,
		SPAN_NEG_J = 2'd3
	} span_sel_t;

	// Queue status seen by the front, the back and the top level.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- design/mcr_req_if.sv -----
`timescale 1ns / 1ps

interface mcr_req_if #(
	parameter int COORD_BITS  = 16,
	parameter int RADIUS_BITS = 12
);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [COORD_BITS-1:0]  center_x;
	logic signed [COORD_BITS-1:0]  center_y;
	logic        [RADIUS_BITS-1:0] radius;
	logic                          filled;

	modport source (
		output valid, req_type, center_x, center_y, radius, filled,
		input  ready
	);

	modport sink (
		input  valid, req_type, center_x, center_y, radius, filled,
		output ready
	);
endinterface

// ----- design/mcr_span_if.sv -----
`timescale 1ns / 1ps

interface mcr_span_if #(
	parameter int COORD_BITS = 16
);
	logic                        valid;
	logic                        ready;
	logic signed [COORD_BITS:0]  column_x;
	logic signed [COORD_BITS:0]  row_low_end;
	logic signed [COORD_BITS:0]  row_high_end;
	logic                        endpoints_only;
	logic                        last;

	modport source (
		output valid, column_x, row_low_end, row_high_end, endpoints_only, last,
		input  ready
	);

	modport sink (
		input  valid, column_x, row_low_end, row_high_end, endpoints_only, last,
		output ready
	);
endinterface

// ----- design/mcr_front.sv -----
`timescale 1ns / 1ps

module mcr_front #(
	parameter int COORD_BITS  = 16,
	parameter int RADIUS_BITS = 12,
	parameter int REC_W       = 2 * (COORD_BITS + 1) + 2 * RADIUS_BITS + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]             cfg_wdata,
	mcr_req_if.sink                           req,
	input  mcr_pkg::q_stat_t                  q_stat,
	output logic                              q_push,
	output logic [REC_W-1:0]                  q_wdata
);
	localparam int S = COORD_BITS + 1;
	localparam int I = RADIUS_BITS + 1;
	localparam int E = RADIUS_BITS + 4;

	logic signed [COORD_BITS-1:0] cam_x_q, cam_y_q;
	logic signed [S-1:0]          cx_q, cy_q, cx0, cy0;
	logic        [I-1:0]          i_q, i0, i_nx;
	logic signed [I-1:0]          j_q, j0, j_nx;
	logic signed [E-1:0]          e_q, e0, e_nx, i_e, j_e, r_e;
	logic                         busy_q, fill_q, fill0;
	logic                         start, done;

	// Camera registers; the user must write them only while idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mcr_pkg::REG_CAMERA_X: cam_x_q <= cfg_wdata;
				mcr_pkg::REG_CAMERA_Y: cam_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Select the step operands: a start loads the new circle, an advance uses the held state.
	always_comb begin
		start = (req.req_type == mcr_pkg::REQ_START);
		r_e   = E'(req.radius);
		if (start) begin
			cx0   = S'(req.center_x) - S'(cam_x_q);
			cy0   = S'(req.center_y) - S'(cam_y_q);
			i0    = '0;
			j0    = I'(req.radius);
			e0    = E'(mcr_pkg::ERR_INIT) - (r_e << 1);
			fill0 = req.filled;
		end else begin
			cx0   = cx_q;
			cy0   = cy_q;
			i0    = i_q;
			j0    = j_q;
			e0    = e_q;
			fill0 = fill_q;
		end
	end

	// Midpoint rule: update the decision term and the octant position.
	always_comb begin
		i_e = E'(i0);
		j_e = E'(j0);
		if (e0[E-1]) begin
			e_nx = e0 + (i_e << 2) + E'(mcr_pkg::STEP_LINEAR);
			j_nx = j0;
		end else begin
			e_nx = e0 + ((i_e - j_e) << 2) + E'(mcr_pkg::STEP_DIAG);
			j_nx = j0 - I'(1);
		end
		i_nx = i0 + I'(1);
		done = $signed({1'b0, i_nx}) > $signed({j_nx[I-1], j_nx});
	end

	// A transaction is taken whenever the queue has room; an advance while idle is dropped.
	assign req.ready = !q_stat.full;
	assign q_push    = req.valid && req.ready && (start || busy_q);
	assign q_wdata   = {cx0, cy0, i0[RADIUS_BITS-1:0], j0[RADIUS_BITS-1:0], !fill0, done};

	// Running state of the circle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (q_push) begin
			busy_q <= !done;
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			cx_q   <= cx0;
			cy_q   <= cy0;
			i_q    <= i_nx;
			j_q    <= j_nx;
			e_q    <= e_nx;
			fill_q <= fill0;
		end
	end
endmodule

// ----- design/mcr_queue.sv -----
`timescale 1ns / 1ps

module mcr_queue #(
	parameter int REC_W = 60
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [REC_W-1:0] wdata,
	input  logic             pop,
	output logic [REC_W-1:0] head,
	output mcr_pkg::q_stat_t stat
);
	logic [REC_W-1:0]                    entry_q [mcr_pkg::QUEUE_DEPTH];
	logic [mcr_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [mcr_pkg::QUEUE_CNT_BITS-1:0]  count_q;

	assign stat.full  = (count_q == mcr_pkg::QUEUE_CNT_BITS'(mcr_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mcr_pkg::QUEUE_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mcr_pkg::QUEUE_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + mcr_pkg::QUEUE_CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - mcr_pkg::QUEUE_CNT_BITS'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end
endmodule

// ----- design/mcr_back.sv -----
`timescale 1ns / 1ps

module mcr_back #(
	parameter int COORD_BITS  = 16,
	parameter int RADIUS_BITS = 12,
	parameter int REC_W       = 2 * (COORD_BITS + 1) + 2 * RADIUS_BITS + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [REC_W-1:0] head,
	input  mcr_pkg::q_stat_t q_stat,
	output logic             q_pop,
	mcr_span_if.source       span
);
	localparam int S = COORD_BITS + 1;
	localparam int R = RADIUS_BITS;
	localparam int W = (S > R) ? S : R;

	logic signed [S-1:0]  cx, cy;
	logic        [R-1:0]  i, j;
	logic                 ends_only, done;
	logic signed [W-1:0]  cx_w, cy_w, i_w, j_w, off_w, col_w;
	logic signed [S-1:0]  col_s, low_s, high_s;
	mcr_pkg::span_sel_t   idx_q, idx_nx;
	logic                 out_valid_q, load;
	logic signed [S-1:0]  col_q, low_q, high_q;
	logic                 ends_q, last_q;

	// Unpack the step record at the queue head.
	assign {cx, cy, i, j, ends_only, done} = head;

	// Span geometry for the current span of the head step.
	always_comb begin
		cx_w = W'(cx);
		cy_w = W'(cy);
		i_w  = W'(i);
		j_w  = W'(j);
		case (idx_q)
			mcr_pkg::SPAN_POS_I: col_w = cx_w + i_w;
			mcr_pkg::SPAN_NEG_I: col_w = cx_w - i_w;
			mcr_pkg::SPAN_POS_J: col_w = cx_w + j_w;
			mcr_pkg::SPAN_NEG_J: col_w = cx_w - j_w;
			default:             col_w = cx_w;
		endcase
		if (idx_q inside {mcr_pkg::SPAN_POS_I, mcr_pkg::SPAN_NEG_I}) begin
			off_w = j_w;
		end else begin
			off_w = i_w;
		end
		col_s  = col_w[S-1:0];
		low_s  = S'(cy_w + off_w);
		high_s = S'(cy_w - off_w);
	end

	// Span sequencer advances when a step is queued and the output register is free or being emptied.
	always_comb begin
		load  = !q_stat.empty && (!out_valid_q || span.ready);
		q_pop = load && (idx_q == mcr_pkg::SPAN_NEG_J);
		case (idx_q)
			mcr_pkg::SPAN_POS_I: idx_nx = mcr_pkg::SPAN_NEG_I;
			mcr_pkg::SPAN_NEG_I: idx_nx = mcr_pkg::SPAN_POS_J;
			mcr_pkg::SPAN_POS_J: idx_nx = mcr_pkg::SPAN_NEG_J;
			mcr_pkg::SPAN_NEG_J: idx_nx = mcr_pkg::SPAN_POS_I;
			default:             idx_nx = mcr_pkg::SPAN_POS_I;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= mcr_pkg::SPAN_POS_I;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= idx_nx;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (span.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load) begin
			col_q  <= col_s;
			low_q  <= low_s;
			high_q <= high_s;
			ends_q <= ends_only;
			last_q <= done && (idx_q == mcr_pkg::SPAN_NEG_J);
		end
	end

	assign span.valid          = out_valid_q;
	assign span.column_x       = col_q;
	assign span.row_low_end    = low_q;
	assign span.row_high_end   = high_q;
	assign span.endpoints_only = ends_q;
	assign span.last           = last_q;
endmodule

// ----- design/midpoint_circle_rasterizer.sv -----
`timescale 1ns / 1ps

// Midpoint circle rasterizer. A start transaction (req_type 0) loads a circle, takes the camera
// offset off its centre and produces the first octant step; each advance transaction (req_type 1)
// produces the next step, and an advance with no circle running is taken and produces nothing.
// Every step yields four vertical spans, one output transaction each, in the order column cx+i,
// cx-i, cx+j, cx-j; the final span of the circle has last set. The front stage runs the
// midpoint recurrence and accepts a request in the cycle it arrives while the two-entry step
// queue has room; the back stage sends one span per cycle through its output register while
// the receiver is ready and a step is queued. A step's first span passes through the step
// queue and then the output register. The user must write the camera registers through the
// cfg port only while no circle output is pending; the block itself does not enforce this.

module midpoint_circle_rasterizer #(
	parameter int COORD_BITS  = 16,
	parameter int RADIUS_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]              cfg_wdata,
	mcr_req_if.sink                            req,
	mcr_span_if.source                         span
);
	localparam int REC_W = 2 * (COORD_BITS + 1) + 2 * RADIUS_BITS + 2;

	logic             q_push, q_pop;
	logic [REC_W-1:0] q_wdata, q_head;
	mcr_pkg::q_stat_t q_stat;

	mcr_front #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS),
		.REC_W       (REC_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	mcr_queue #(
		.REC_W (REC_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	mcr_back #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS),
		.REC_W       (REC_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.span   (span)
	);

	// The front never writes a step into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_stat.full))
		else $error("step written into full queue");

	// The back never retires a step from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(q_pop && q_stat.empty))
		else $error("step retired from empty queue");

	// A step written without a retire leaves the queue non-empty.
	assert property (@(posedge clk) disable iff (!arst_n) (q_push && !q_pop) |=> !q_stat.empty)
		else $error("queue empty after step write");

	// A span is only offered after a step has been held in the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		($rose(span.valid)) |-> $past(!q_stat.empty))
		else $error("span offered without a queued step");
endmodule

// ----- tb/sv/mcr_span_checker.sv -----
`timescale 1ns / 1ps

module mcr_span_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [15:0]                        cfg_wdata,
	mcr_req_if                                 req,
	mcr_span_if                                span,
	output int                                 mismatches,
	output int                                 outstanding
);
	typedef struct packed {
		logic signed [16:0] column_x;
		logic signed [16:0] row_low_end;
		logic signed [16:0] row_high_end;
		logic               endpoints_only;
		logic               last;
	} span_t;

	// Shadow of the camera registers and of the circle being traced.
	logic signed [15:0] cam_x;
	logic signed [15:0] cam_y;
	int                 ctr_x;
	int                 ctr_y;
	int                 arc_i;
	int                 arc_j;
	int                 midpoint_err;
	bit                 tracing;
	bit                 solid;
	span_t              due_spans[$];
	span_t              want;

	// Builds one span around the current centre; values wrap to 17 bits.
	function automatic span_t make_span(int col, int off, bit final_span);
		span_t s;
		s.column_x       = 17'(col);
		s.row_low_end    = 17'(ctr_y + off);
		s.row_high_end   = 17'(ctr_y - off);
		s.endpoints_only = !solid;
		s.last           = final_span;
		return s;
	endfunction

	// One octant step: update the decision term, then queue the four spans of (i, j).
	task automatic plot_octant_step();
		int i;
		int j;
		bit done;
		i = arc_i;
		j = arc_j;
		if (midpoint_err < 0) begin
			midpoint_err += 4 * i + mcr_pkg::STEP_LINEAR;
		end else begin
			midpoint_err += 4 * (i - j) + mcr_pkg::STEP_DIAG;
			arc_j = j - 1;
		end
		arc_i = i + 1;
		done = (arc_i > arc_j);
		due_spans.push_back(make_span(ctr_x + i, j, 1'b0));
		due_spans.push_back(make_span(ctr_x - i, j, 1'b0));
		due_spans.push_back(make_span(ctr_x + j, i, 1'b0));
		due_spans.push_back(make_span(ctr_x - j, i, done));
		if (done) begin
			tracing = 1'b0;
		end
	endtask

	task automatic check_field(string name, logic signed [31:0] expected,
			logic signed [31:0] actual);
		if (expected !== actual) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			mismatches++;
		end
	endtask

	// Everything is sampled at the rising edge, before the block's own updates land.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x        = '0;
			cam_y        = '0;
			ctr_x        = 0;
			ctr_y        = 0;
			arc_i        = 0;
			arc_j        = 0;
			midpoint_err = 0;
			tracing      = 1'b0;
			solid        = 1'b0;
			due_spans.delete();
			mismatches   = 0;
			outstanding  = 0;
		end else begin
			// Register writes take effect at once, also for a transaction in the same cycle.
			if (cfg_we) begin
				if (cfg_index == mcr_pkg::REG_CAMERA_X) begin
					cam_x = cfg_wdata;
				end else if (cfg_index == mcr_pkg::REG_CAMERA_Y) begin
					cam_y = cfg_wdata;
				end
			end

			// A start always begins a new circle; an advance only counts while one runs.
			if (req.valid && req.ready) begin
				if (req.req_type == mcr_pkg::REQ_START) begin
					ctr_x        = int'(req.center_x) - int'(cam_x);
					ctr_y        = int'(req.center_y) - int'(cam_y);
					solid        = req.filled;
					arc_i        = 0;
					arc_j        = int'(req.radius);
					midpoint_err = mcr_pkg::ERR_INIT - 2 * int'(req.radius);
					tracing      = 1'b1;
					plot_octant_step();
				end else if (tracing) begin
					plot_octant_step();
				end
			end

			// Compare each span transaction with the oldest expected span.
			if (span.valid && span.ready) begin
				if (due_spans.size() == 0) begin
					$error("span transaction arrived with no expected span waiting");
					mismatches++;
				end else begin
					want = due_spans.pop_front();
					check_field("column_x", want.column_x, span.column_x);
					check_field("row_low_end", want.row_low_end, span.row_low_end);
					check_field("row_high_end", want.row_high_end, span.row_high_end);
					check_field("endpoints_only", want.endpoints_only, span.endpoints_only);
					check_field("last", want.last, span.last);
				end
			end
			outstanding = due_spans.size();
		end
	end
endmodule

// ----- tb/sv/tb_midpoint_circle_rasterizer.sv -----
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer;
	localparam int LIMIT = 400000;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [mcr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [15:0]                        cfg_wdata;
	int                                 mismatches;
	int                                 outstanding;
	int                                 send_calm;
	int                                 sink_calm;

	mcr_req_if  req_ch ();
	mcr_span_if span_ch ();

	midpoint_circle_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.span      (span_ch)
	);

	mcr_span_checker u_span_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.span        (span_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Random wait before a transaction, with occasional stretches of back-to-back transactions.
	function automatic int pick_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 4);
	endfunction

	// Centres lean towards the extremes so that screen coordinates wrap now and then.
	function automatic logic signed [15:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Valid stays high between back-to-back requests; it only drops for a gap.
	task automatic send_req(input logic kind, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic [11:0] r, input logic f);
		int gap;
		gap = pick_wait(send_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.req_type <= kind;
		req_ch.center_x <= x;
		req_ch.center_y <= y;
		req_ch.radius   <= r;
		req_ch.filled   <= f;
		req_ch.valid    <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// The start-only fields are don't-care on an advance, so they carry noise.
	task automatic send_advance();
		send_req(mcr_pkg::REQ_ADVANCE, 16'($urandom), 16'($urandom), 12'($urandom),
			1'($urandom));
	endtask

	// Drain every outstanding span, then allow for an advance that may still be in flight.
	task automatic quiesce();
		req_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_camera(input logic [15:0] x, input logic [15:0] y);
		cfg_we    <= 1'b1;
		cfg_index <= mcr_pkg::REG_CAMERA_X;
		cfg_wdata <= x;
		@(negedge clk);
		cfg_index <= mcr_pkg::REG_CAMERA_Y;
		cfg_wdata <= y;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// An optional random request, then a start followed by enough advances to finish the circle,
	// sometimes cut short by the next start and sometimes overrunning into advances while idle.
	task automatic trace_random_circle(inout int productive);
		int r;
		int n;
		int full;
		if ($urandom_range(0, 7) == 0) begin
			send_req(1'($urandom), 16'($urandom), 16'($urandom), 12'($urandom), 1'($urandom));
		end
		case ($urandom_range(0, 9))
			0: begin
				r = $urandom_range(0, 4095);
				n = $urandom_range(1, 8);
			end
			1: begin
				r = 0;
				n = $urandom_range(0, 2);
			end
			default: begin
				r = $urandom_range(1, 40);
				n = (r * 7) / 10 + $urandom_range(0, 2);
				if ($urandom_range(0, 5) == 0) begin
					n = $urandom_range(0, n);
				end
			end
		endcase
		full = (r * 7) / 10;
		send_req(mcr_pkg::REQ_START, pick_coord(), pick_coord(), 12'(r), 1'($urandom));
		productive += 1 + ((n < full) ? n : full);
		repeat (n) send_advance();
	endtask

	// Span receiver with its own stalls and two long hold-offs that back up the block.
	initial begin : span_sink
		int stall;
		int taken;
		span_ch.ready = 1'b0;
		sink_calm     = 0;
		taken         = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 100 || taken == 900) begin
				span_ch.ready <= 1'b0;
				repeat (300) @(negedge clk);
			end else begin
				stall = pick_wait(sink_calm);
				if (stall > 0) begin
					span_ch.ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			span_ch.ready <= 1'b1;
			do @(posedge clk); while (!span_ch.valid);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int productive;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = mcr_pkg::REG_CAMERA_X;
		cfg_wdata       = '0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = mcr_pkg::REQ_START;
		req_ch.center_x = '0;
		req_ch.center_y = '0;
		req_ch.radius   = '0;
		req_ch.filled   = 1'b0;
		send_calm       = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: idle advance, zero radius, extremes, restart while busy.
		set_camera(16'sd100, -16'sd50);
		send_advance();
		send_req(mcr_pkg::REQ_START, 16'sd0, 16'sd0, 12'd0, 1'b0);
		send_req(mcr_pkg::REQ_START, 16'sh7fff, 16'sh8000, 12'd0, 1'b1);
		send_advance();
		send_req(mcr_pkg::REQ_START, 16'sh8000, 16'sh7fff, 12'd4095, 1'b1);
		repeat (2) send_advance();
		send_req(mcr_pkg::REQ_START, 16'sd123, -16'sd456, 12'd5, 1'b0);
		repeat (6) send_advance();
		send_req(mcr_pkg::REQ_START, -16'sd7, 16'sd9, 12'd1, 1'b1);
		repeat (3) send_advance();
		send_req(mcr_pkg::REQ_START, pick_coord(), pick_coord(), 12'd2048, 1'b0);
		repeat (2) send_advance();
		quiesce();

		// Random part over several camera settings, extremes included.
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_camera(16'h7fff, 16'h8000);
				1: set_camera(16'h8000, 16'h7fff);
				2: set_camera(16'h0000, 16'h0000);
				default: set_camera(16'($urandom), 16'($urandom));
			endcase
			productive = 0;
			while (productive < 70) trace_random_circle(productive);
			quiesce();
		end

		repeat (20) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
